[src/rusi_pkg.sv]
// rusi_pkg: shared field widths, defaults and payload types for the
// ray / unit sphere intersection block. No dependencies.
`default_nettype none

package rusi_pkg;

    localparam int FIELD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int AXES          = 3;

    typedef logic signed [FIELD_W-1:0] fix_t;

    localparam fix_t FIX_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    typedef struct packed {
        fix_t [AXES-1:0] o;
        fix_t [AXES-1:0] v;
    } ray_t;

    typedef struct packed {
        logic            hit;
        fix_t            distance;
        fix_t [AXES-1:0] imp;
    } res_t;

endpackage

`default_nettype wire

[src/ray_unit_sphere_intersect.sv]
// From input transaction to out_valid the path is mostly the one-bit-per-stage square root
// (64 stages) and the two one-bit-per-stage dividers (65 + FRACTION_BITS stages; Q16.16 by
// default) running side by side.
// Throughput: one transaction per cycle; output register plus one skid entry, and the
// pipeline freezes only while the skid entry is full.
// Reset (rst_n low, asynchronous) clears all valid bits; no other state. Depends on rusi_pkg.
`default_nettype none

module ray_unit_sphere_intersect #(
    parameter int FRACTION_BITS = rusi_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rusi_pkg::FIELD_W-1:0] origin_x,
    input  logic signed [rusi_pkg::FIELD_W-1:0] origin_y,
    input  logic signed [rusi_pkg::FIELD_W-1:0] origin_z,
    input  logic signed [rusi_pkg::FIELD_W-1:0] direction_x,
    input  logic signed [rusi_pkg::FIELD_W-1:0] direction_y,
    input  logic signed [rusi_pkg::FIELD_W-1:0] direction_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic signed [rusi_pkg::FIELD_W-1:0] hit_distance,
    output logic signed [rusi_pkg::FIELD_W-1:0] impact_x,
    output logic signed [rusi_pkg::FIELD_W-1:0] impact_y,
    output logic signed [rusi_pkg::FIELD_W-1:0] impact_z
);
    import rusi_pkg::*;

    localparam int FW   = FIELD_W;
    localparam int PW   = 2*FW;
    localparam int HW   = PW+1;
    localparam int DW   = 2*PW;
    localparam int SW   = PW;
    localparam int QW   = PW+1;
    localparam int NW   = QW+FRACTION_BITS;
    localparam int TW   = NW+1;
    localparam int TL   = (NW+FW-1)/FW;
    localparam int MW   = TL*FW+FW;
    localparam int EW   = MW+2;
    localparam int SATW = (TW > EW) ? TW : EW;

    typedef struct packed {
        ray_t          ray;
        logic [PW-1:0] a;
        logic          a_zero;
        logic [PW-1:0] h_mag;
        logic          h_pos;
        logic [PW-1:0] cm_mag;
        logic          cm_neg;
        logic          d_neg;
        logic          d_zero;
        logic [QW-1:0] q_mag;
    } side_t;

    function automatic fix_t sat_fix(input logic signed [SATW-1:0] x);
        logic signed [SATW-1:0] hi_lim;
        logic signed [SATW-1:0] lo_lim;
        hi_lim = SATW'(FIX_MAX);
        lo_lim = SATW'(FIX_MIN);
        if (x > hi_lim)
            return FIX_MAX;
        else if (x < lo_lim)
            return FIX_MIN;
        else
            return x[FW-1:0];
    endfunction

    logic en;
    logic skid_v_reg;
    logic out_v_reg;
    res_t skid_reg;
    res_t out_reg;

    assign en       = !skid_v_reg;
    assign in_ready = en;

    // ---------------- stage 1: squares and dot terms ----------------
    ray_t in_ray;
    logic signed [PW-1:0] vv_c [AXES];
    logic signed [PW-1:0] vo_c [AXES];
    logic signed [PW-1:0] oo_c [AXES];

    always_comb
    begin
        in_ray.o[0] = origin_x;
        in_ray.o[1] = origin_y;
        in_ray.o[2] = origin_z;
        in_ray.v[0] = direction_x;
        in_ray.v[1] = direction_y;
        in_ray.v[2] = direction_z;
        for (int i = 0; i < AXES; i++)
        begin
            vv_c[i] = $signed(in_ray.v[i]) * $signed(in_ray.v[i]);
            vo_c[i] = $signed(in_ray.v[i]) * $signed(in_ray.o[i]);
            oo_c[i] = $signed(in_ray.o[i]) * $signed(in_ray.o[i]);
        end
    end

    logic                 s1_v_reg;
    ray_t                 s1_ray_reg;
    logic signed [PW-1:0] s1_vv_reg [AXES];
    logic signed [PW-1:0] s1_vo_reg [AXES];
    logic signed [PW-1:0] s1_oo_reg [AXES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ray_reg <= in_ray;
            s1_vv_reg  <= vv_c;
            s1_vo_reg  <= vo_c;
            s1_oo_reg  <= oo_c;
        end
    end

    // ---------------- stage 2: A, H, C - 1 ----------------
    logic signed [HW-1:0] a_c, h_c, cm_c;

    always_comb
    begin
        a_c  = '0;
        h_c  = '0;
        cm_c = -(HW'(1) <<< (2*FRACTION_BITS));
        for (int i = 0; i < AXES; i++)
        begin
            a_c  = a_c  + HW'(s1_vv_reg[i]);
            h_c  = h_c  + HW'(s1_vo_reg[i]);
            cm_c = cm_c + HW'(s1_oo_reg[i]);
        end
    end

    logic                 s2_v_reg;
    ray_t                 s2_ray_reg;
    logic signed [HW-1:0] s2_a_reg, s2_h_reg, s2_cm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ray_reg <= s1_ray_reg;
            s2_a_reg   <= a_c;
            s2_h_reg   <= h_c;
            s2_cm_reg  <= cm_c;
        end
    end

    // ---------------- stage 3: magnitudes and signs ----------------
    side_t                s3_next;
    logic signed [HW-1:0] h_abs, cm_abs;

    always_comb
    begin
        h_abs  = s2_h_reg[HW-1]  ? -s2_h_reg  : s2_h_reg;
        cm_abs = s2_cm_reg[HW-1] ? -s2_cm_reg : s2_cm_reg;
        s3_next        = '0;
        s3_next.ray    = s2_ray_reg;
        s3_next.a      = s2_a_reg[PW-1:0];
        s3_next.a_zero = (s2_a_reg == '0);
        s3_next.h_mag  = h_abs[PW-1:0];
        s3_next.h_pos  = !s2_h_reg[HW-1] && (s2_h_reg != '0);
        s3_next.cm_mag = cm_abs[PW-1:0];
        s3_next.cm_neg = s2_cm_reg[HW-1];
    end

    logic  s3_v_reg;
    side_t s3_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            s3_side_reg <= s3_next;
    end

    // ---------------- stage 4: 32x32 partial products ----------------
    logic [PW-1:0] hll_c, hlh_c, hhh_c, all_c, alh_c, ahl_c, ahh_c;

    always_comb
    begin
        hll_c = s3_side_reg.h_mag[FW-1:0]  * s3_side_reg.h_mag[FW-1:0];
        hlh_c = s3_side_reg.h_mag[FW-1:0]  * s3_side_reg.h_mag[PW-1:FW];
        hhh_c = s3_side_reg.h_mag[PW-1:FW] * s3_side_reg.h_mag[PW-1:FW];
        all_c = s3_side_reg.a[FW-1:0]      * s3_side_reg.cm_mag[FW-1:0];
        alh_c = s3_side_reg.a[FW-1:0]      * s3_side_reg.cm_mag[PW-1:FW];
        ahl_c = s3_side_reg.a[PW-1:FW]     * s3_side_reg.cm_mag[FW-1:0];
        ahh_c = s3_side_reg.a[PW-1:FW]     * s3_side_reg.cm_mag[PW-1:FW];
    end

    logic          s4_v_reg;
    side_t         s4_side_reg;
    logic [PW-1:0] s4_hll_reg, s4_hlh_reg, s4_hhh_reg;
    logic [PW-1:0] s4_all_reg, s4_alh_reg, s4_ahl_reg, s4_ahh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s3_side_reg;
            s4_hll_reg  <= hll_c;
            s4_hlh_reg  <= hlh_c;
            s4_hhh_reg  <= hhh_c;
            s4_all_reg  <= all_c;
            s4_alh_reg  <= alh_c;
            s4_ahl_reg  <= ahl_c;
            s4_ahh_reg  <= ahh_c;
        end
    end

    // ---------------- stage 5: H^2 and A*|C-1| ----------------
    logic [DW-1:0] h2_c, acm_c;

    always_comb
    begin
        h2_c  = (DW'(s4_hhh_reg) << PW) + (DW'(s4_hlh_reg) << (FW+1)) + DW'(s4_hll_reg);
        acm_c = (DW'(s4_ahh_reg) << PW) + ((DW'(s4_alh_reg) + DW'(s4_ahl_reg)) << FW)
              + DW'(s4_all_reg);
    end

    logic          s5_v_reg;
    side_t         s5_side_reg;
    logic [DW-1:0] s5_h2_reg, s5_acm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s4_side_reg;
            s5_h2_reg   <= h2_c;
            s5_acm_reg  <= acm_c;
        end
    end

    // ---------------- stage 6: discriminant ----------------
    logic [DW+1:0] d_c;
    side_t         s6_next;

    always_comb
    begin
        if (s5_side_reg.cm_neg)
            d_c = {2'b00, s5_h2_reg} + {2'b00, s5_acm_reg};
        else
            d_c = {2'b00, s5_h2_reg} - {2'b00, s5_acm_reg};
        s6_next       = s5_side_reg;
        s6_next.d_neg = d_c[DW+1];
    end

    logic          s6_v_reg;
    side_t         s6_side_reg;
    logic [DW-1:0] s6_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_side_reg <= s6_next;
            s6_d_reg    <= d_c[DW-1:0];
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic          sq_v_reg    [0:SW];
    side_t         sq_side_reg [0:SW];
    logic [SW+1:0] sq_rem_reg  [0:SW];
    logic [SW-1:0] sq_root_reg [0:SW];
    logic [DW-1:0] sq_rad_reg  [0:SW];
    side_t         sq0_next;

    always_comb
    begin
        sq0_next        = s6_side_reg;
        sq0_next.d_zero = (s6_d_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= sq0_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= s6_d_reg;
        end
    end

    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        logic [SW+3:0] sq_cur, sq_trial, sq_diff;
        logic          sq_ge;

        always_comb
        begin
            sq_cur   = {sq_rem_reg[k], sq_rad_reg[k][DW-1 -: 2]};
            sq_trial = {2'b00, sq_root_reg[k], 2'b01};
            sq_diff  = sq_cur - sq_trial;
            sq_ge    = (sq_cur >= sq_trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (en)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_rem_reg[k+1]  <= sq_ge ? sq_diff[SW+1:0] : sq_cur[SW+1:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][SW-2:0], sq_ge};
                sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
            end
        end
    end

    // ---------------- Q and divider setup ----------------
    logic          dv_v_reg    [0:NW];
    side_t         dv_side_reg [0:NW];
    logic [QW-1:0] dv_rem0_reg [0:NW];
    logic [NW-1:0] dv_num0_reg [0:NW];
    logic [NW-1:0] dv_quo0_reg [0:NW];
    logic [QW-1:0] dv_rem1_reg [0:NW];
    logic [NW-1:0] dv_num1_reg [0:NW];
    logic [NW-1:0] dv_quo1_reg [0:NW];
    side_t         dv0_next;

    always_comb
    begin
        dv0_next       = sq_side_reg[SW];
        dv0_next.q_mag = QW'(sq_side_reg[SW].h_mag) + QW'(sq_root_reg[SW]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= dv0_next;
            dv_rem0_reg[0] <= '0;
            dv_num0_reg[0] <= NW'(dv0_next.q_mag) << FRACTION_BITS;
            dv_quo0_reg[0] <= '0;
            dv_rem1_reg[0] <= '0;
            dv_num1_reg[0] <= NW'(dv0_next.cm_mag) << FRACTION_BITS;
            dv_quo1_reg[0] <= '0;
        end
    end

    // t0 = |Q| * 2^F / A and t1 = |C-1| * 2^F / |Q|, one quotient bit per stage
    for (genvar j = 0; j < NW; j++)
    begin : g_div
        logic [QW:0] dv_cur0, dv_den0, dv_diff0;
        logic [QW:0] dv_cur1, dv_den1, dv_diff1;
        logic        dv_ge0, dv_ge1;

        always_comb
        begin
            dv_cur0  = {dv_rem0_reg[j], dv_num0_reg[j][NW-1]};
            dv_den0  = {2'b00, dv_side_reg[j].a};
            dv_diff0 = dv_cur0 - dv_den0;
            dv_ge0   = (dv_cur0 >= dv_den0);
            dv_cur1  = {dv_rem1_reg[j], dv_num1_reg[j][NW-1]};
            dv_den1  = {1'b0, dv_side_reg[j].q_mag};
            dv_diff1 = dv_cur1 - dv_den1;
            dv_ge1   = (dv_cur1 >= dv_den1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else if (en)
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                dv_rem0_reg[j+1] <= dv_ge0 ? dv_diff0[QW-1:0] : dv_cur0[QW-1:0];
                dv_num0_reg[j+1] <= dv_num0_reg[j] << 1;
                dv_quo0_reg[j+1] <= {dv_quo0_reg[j][NW-2:0], dv_ge0};
                dv_rem1_reg[j+1] <= dv_ge1 ? dv_diff1[QW-1:0] : dv_cur1[QW-1:0];
                dv_num1_reg[j+1] <= dv_num1_reg[j] << 1;
                dv_quo1_reg[j+1] <= {dv_quo1_reg[j][NW-2:0], dv_ge1};
            end
        end
    end

    // ---------------- stage 8: signed roots ----------------
    logic signed [TW-1:0] t0_c, t1_c;
    side_t                dv_last;

    always_comb
    begin
        dv_last = dv_side_reg[NW];
        t0_c    = TW'(dv_quo0_reg[NW]);
        t1_c    = TW'(dv_quo1_reg[NW]);
        if (dv_last.h_pos)
            t0_c = -t0_c;
        if (dv_last.cm_neg ^ dv_last.h_pos)
            t1_c = -t1_c;
        if (dv_last.d_zero)
            t1_c = t0_c;
    end

    logic                 s8_v_reg;
    side_t                s8_side_reg;
    logic signed [TW-1:0] s8_t0_reg, s8_t1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_side_reg <= dv_last;
            s8_t0_reg   <= t0_c;
            s8_t1_reg   <= t1_c;
        end
    end

    // ---------------- stage 9: order roots, pick nearest nonnegative ----------------
    logic signed [TW-1:0] lo_c, hi_c, t_c;
    logic                 hit_c;

    always_comb
    begin
        if (s8_t0_reg > s8_t1_reg)
        begin
            lo_c = s8_t1_reg;
            hi_c = s8_t0_reg;
        end
        else
        begin
            lo_c = s8_t0_reg;
            hi_c = s8_t1_reg;
        end
        t_c   = lo_c[TW-1] ? hi_c : lo_c;
        hit_c = !s8_side_reg.a_zero && !s8_side_reg.d_neg && !(lo_c[TW-1] && hi_c[TW-1]);
    end

    logic                 s9_v_reg;
    logic                 s9_hit_reg;
    logic signed [TW-1:0] s9_t_reg;
    ray_t                 s9_ray_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_hit_reg <= hit_c;
            s9_t_reg   <= t_c;
            s9_ray_reg <= s8_side_reg.ray;
        end
    end

    // ---------------- stage 10: magnitudes for t*V ----------------
    logic signed [TW-1:0] t_abs;
    logic [FW-1:0]        vmag_c [AXES];

    always_comb
    begin
        t_abs = s9_t_reg[TW-1] ? -s9_t_reg : s9_t_reg;
        for (int i = 0; i < AXES; i++)
            vmag_c[i] = s9_ray_reg.v[i][FW-1] ? -s9_ray_reg.v[i] : s9_ray_reg.v[i];
    end

    logic               s10_v_reg;
    logic               s10_hit_reg;
    fix_t               s10_tsat_reg;
    logic [TL*FW-1:0]   s10_tmag_reg;
    logic               s10_tneg_reg;
    logic [FW-1:0]      s10_vmag_reg [AXES];
    logic [AXES-1:0]    s10_vneg_reg;
    ray_t               s10_ray_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_hit_reg  <= s9_hit_reg;
            s10_tsat_reg <= sat_fix(SATW'(s9_t_reg));
            s10_tmag_reg <= (TL*FW)'(t_abs[NW-1:0]);
            s10_tneg_reg <= s9_t_reg[TW-1];
            s10_vmag_reg <= vmag_c;
            for (int i = 0; i < AXES; i++)
                s10_vneg_reg[i] <= s9_ray_reg.v[i][FW-1];
            s10_ray_reg  <= s9_ray_reg;
        end
    end

    // ---------------- stage 11: limb products ----------------
    logic [PW-1:0] pp_c [AXES][TL];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            for (int l = 0; l < TL; l++)
                pp_c[i][l] = s10_tmag_reg[l*FW +: FW] * s10_vmag_reg[i];
    end

    logic            s11_v_reg;
    logic            s11_hit_reg;
    fix_t            s11_tsat_reg;
    logic [PW-1:0]   s11_pp_reg [AXES][TL];
    logic [AXES-1:0] s11_neg_reg;
    ray_t            s11_ray_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_hit_reg  <= s10_hit_reg;
            s11_tsat_reg <= s10_tsat_reg;
            s11_pp_reg   <= pp_c;
            s11_neg_reg  <= s10_vneg_reg ^ {AXES{s10_tneg_reg}};
            s11_ray_reg  <= s10_ray_reg;
        end
    end

    // ---------------- stage 12: product sum, drop fraction ----------------
    logic [MW-1:0] pm_c [AXES];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            pm_c[i] = '0;
            for (int l = 0; l < TL; l++)
                pm_c[i] = pm_c[i] + (MW'(s11_pp_reg[i][l]) << (FW*l));
            pm_c[i] = pm_c[i] >> FRACTION_BITS;
        end
    end

    logic            s12_v_reg;
    logic            s12_hit_reg;
    fix_t            s12_tsat_reg;
    logic [MW-1:0]   s12_pm_reg [AXES];
    logic [AXES-1:0] s12_neg_reg;
    ray_t            s12_ray_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s12_hit_reg  <= s11_hit_reg;
            s12_tsat_reg <= s11_tsat_reg;
            s12_pm_reg   <= pm_c;
            s12_neg_reg  <= s11_neg_reg;
            s12_ray_reg  <= s11_ray_reg;
        end
    end

    // ---------------- stage 13: apply sign ----------------
    logic signed [EW-1:0] term_c [AXES];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            term_c[i] = EW'(s12_pm_reg[i]);
            if (s12_neg_reg[i])
                term_c[i] = -term_c[i];
        end
    end

    logic                 s13_v_reg;
    logic                 s13_hit_reg;
    fix_t                 s13_tsat_reg;
    logic signed [EW-1:0] s13_term_reg [AXES];
    ray_t                 s13_ray_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s13_hit_reg  <= s12_hit_reg;
            s13_tsat_reg <= s12_tsat_reg;
            s13_term_reg <= term_c;
            s13_ray_reg  <= s12_ray_reg;
        end
    end

    // ---------------- stage 14: O + t*V ----------------
    logic signed [EW-1:0] sum_c [AXES];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            sum_c[i] = s13_term_reg[i] + EW'($signed(s13_ray_reg.o[i]));
    end

    logic                 s14_v_reg;
    logic                 s14_hit_reg;
    fix_t                 s14_tsat_reg;
    logic signed [EW-1:0] s14_sum_reg [AXES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s14_hit_reg  <= s13_hit_reg;
            s14_tsat_reg <= s13_tsat_reg;
            s14_sum_reg  <= sum_c;
        end
    end

    // ---------------- stage 15: saturate, zero on miss ----------------
    res_t res_c;

    always_comb
    begin
        res_c     = '0;
        res_c.hit = s14_hit_reg;
        if (s14_hit_reg)
        begin
            res_c.distance = s14_tsat_reg;
            for (int i = 0; i < AXES; i++)
                res_c.imp[i] = sat_fix(SATW'(s14_sum_reg[i]));
        end
    end

    logic f_v_reg;
    res_t f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            f_reg <= res_c;
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
            s6_v_reg    <= 1'b0;
            sq_v_reg[0] <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            s8_v_reg    <= 1'b0;
            s9_v_reg    <= 1'b0;
            s10_v_reg   <= 1'b0;
            s11_v_reg   <= 1'b0;
            s12_v_reg   <= 1'b0;
            s13_v_reg   <= 1'b0;
            s14_v_reg   <= 1'b0;
            f_v_reg     <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= in_valid;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            s6_v_reg    <= s5_v_reg;
            sq_v_reg[0] <= s6_v_reg;
            dv_v_reg[0] <= sq_v_reg[SW];
            s8_v_reg    <= dv_v_reg[NW];
            s9_v_reg    <= s8_v_reg;
            s10_v_reg   <= s9_v_reg;
            s11_v_reg   <= s10_v_reg;
            s12_v_reg   <= s11_v_reg;
            s13_v_reg   <= s12_v_reg;
            s14_v_reg   <= s13_v_reg;
            f_v_reg     <= s14_v_reg;
        end
    end

    // ---------------- output register and skid entry ----------------
    logic out_take;

    assign out_take = !out_v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_take)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (f_v_reg)
        begin
            if (out_take)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (f_v_reg)
        begin
            if (out_take)
                out_reg <= f_reg;
            else
                skid_reg <= f_reg;
        end
    end

    assign out_valid    = out_v_reg;
    assign hit          = out_reg.hit;
    assign hit_distance = out_reg.distance;
    assign impact_x     = out_reg.imp[0];
    assign impact_y     = out_reg.imp[1];
    assign impact_z     = out_reg.imp[2];

endmodule

`default_nettype wire

[src/rusi_checker.sv]
// rusi_checker: port-level assertions for ray_unit_sphere_intersect, bound to the top level.
// Depends on rusi_pkg.
`default_nettype none

module rusi_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] origin_x,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] origin_y,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] origin_z,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] direction_x,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] direction_y,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] direction_z,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic                                hit,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] hit_distance,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] impact_x,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] impact_y,
    input wire logic signed [rusi_pkg::FIELD_W-1:0] impact_z
);
    import rusi_pkg::*;

    // stalled transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_distance)
            && $stable(impact_x) && $stable(impact_y) && $stable(impact_z))
        else $error("output transaction changed while stalled");

    // a miss reports all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == '0 && impact_x == '0
            && impact_y == '0 && impact_z == '0)
        else $error("miss with nonzero fields");

    // the chosen root is never negative
    a_hit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !hit_distance[FIELD_W-1])
        else $error("hit with negative distance");

    // one-entry skid: once the input side has closed during an output stall, it stays closed until the stall ends
    a_skid_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_ready |=> !in_ready || $past(out_ready) || out_ready
            || !out_valid)
        else $error("input side reopened during output stall");

endmodule

bind ray_unit_sphere_intersect rusi_checker u_rusi_checker (.*);

`default_nettype wire
